FILE: design/ilc_pkg.sv
package ilc_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_EVENT = 2'd2
   } ilc_op_type;

   // word numbers inside the 32-byte window
   localparam logic [2:0] WORD_STATUS = 3'd0;
   localparam logic [2:0] WORD_MASK   = 3'd1;
   localparam logic [2:0] WORD_LEVEL0 = 3'd4;
   localparam logic [2:0] WORD_LEVEL1 = 3'd5;
   localparam logic [2:0] WORD_LEVEL2 = 3'd6;
   localparam logic [2:0] WORD_LEVEL3 = 3'd7;

   // port numbers beyond the sources
   localparam logic [4:0] PORT_SPECIAL = 5'd16;
   localparam logic [4:0] PORT_RESET   = 5'd17;

   // priority numbers
   localparam logic [5:0] IP_CLEAR   = 6'd0;
   localparam logic [5:0] IP_BASE    = 6'd16;
   localparam logic [5:0] IP_SPECIAL = 6'd32;

   localparam logic [31:0] STATUS_RESET = 32'h0000_ffff;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   typedef struct packed {
      logic [1:0] opcode;
      logic [4:0] byte_offset;
      logic [7:0] write_byte;
      logic [4:0] port_id;
      logic       level_nonzero;
      logic       last_of_access;
   } ilc_req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       ip_valid;
      logic [5:0] irq_number;
      logic       access_done;
   } ilc_rsp_type;

   typedef struct packed {
      logic fire;
      logic big_endian_lanes;
   } ilc_ctrl_type;

endpackage

FILE: design/ilc_stream_if.sv
interface ilc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input ready, input payload);
endinterface

FILE: design/ilc_regfile.sv
module ilc_regfile #(
   parameter int NUM_SOURCES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ilc_pkg::ilc_ctrl_type ctrl,
   input  ilc_pkg::ilc_req_type  req,
   output ilc_pkg::ilc_rsp_type  rsp
);

   logic [31:0] status_ff, status_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] level_ff [4];
   logic [31:0] level_in [4];

   logic [2:0]  word_sel;
   logic [1:0]  lane_sel;
   logic [31:0] cur_word;
   logic [31:0] new_word;
   logic        word_used;
   logic [3:0]  src;
   logic [2:0]  src_level;
   logic        src_in_range;
   logic        src_passes;

   assign word_sel = req.byte_offset[4:2];
   assign lane_sel = ctrl.big_endian_lanes ? ~req.byte_offset[1:0] : req.byte_offset[1:0];

   always_comb begin
      word_used = 1'b1;
      case (word_sel) inside
         ilc_pkg::WORD_STATUS: cur_word = status_ff;
         ilc_pkg::WORD_MASK:   cur_word = mask_ff;
         ilc_pkg::WORD_LEVEL0, ilc_pkg::WORD_LEVEL1,
         ilc_pkg::WORD_LEVEL2, ilc_pkg::WORD_LEVEL3: begin
            cur_word = level_ff[word_sel[1:0]];
         end
         default: begin
            cur_word  = '0;
            word_used = 1'b0;
         end
      endcase
   end

   // byte merge for writes
   always_comb begin
      new_word = cur_word;
      for (int i = 0; i < 4; i++) begin
         if (2'(i) == lane_sel) new_word[i*8 +: 8] = req.write_byte;
      end
   end

   assign src          = req.port_id[3:0];
   assign src_level    = level_ff[src[3:2]][{src[1:0], 3'b000} +: 3];
   assign src_in_range = 32'(req.port_id) < 32'(NUM_SOURCES);
   // level beats the whole mask word, compared unsigned
   assign src_passes   = (mask_ff[31:3] == '0) && (src_level > mask_ff[2:0]);

   always_comb begin
      status_in = status_ff;
      mask_in   = mask_ff;
      for (int i = 0; i < 4; i++) level_in[i] = level_ff[i];
      rsp       = '0;

      unique case (req.opcode)
         ilc_pkg::OP_READ: begin
            rsp.access_done = req.last_of_access;
            rsp.read_byte   = cur_word[{lane_sel, 3'b000} +: 8];
         end
         ilc_pkg::OP_WRITE: begin
            rsp.access_done = req.last_of_access;
            if (word_used) begin
               if (word_sel == ilc_pkg::WORD_STATUS) status_in = new_word;
               else if (word_sel == ilc_pkg::WORD_MASK) mask_in = new_word;
               else level_in[word_sel[1:0]] = new_word;
            end
         end
         ilc_pkg::OP_EVENT: begin
            if (!req.level_nonzero) begin
               rsp.ip_valid   = 1'b1;
               rsp.irq_number = ilc_pkg::IP_CLEAR;
            end else if (src_in_range) begin
               status_in = status_ff & ~(32'd1 << src);
               if (src_passes) begin
                  rsp.ip_valid   = 1'b1;
                  rsp.irq_number = ilc_pkg::IP_BASE + 6'(src);
               end
            end else if (req.port_id == ilc_pkg::PORT_SPECIAL) begin
               rsp.ip_valid   = 1'b1;
               rsp.irq_number = ilc_pkg::IP_SPECIAL;
            end else if (req.port_id == ilc_pkg::PORT_RESET) begin
               status_in = ilc_pkg::STATUS_RESET;
               mask_in   = '0;
               for (int i = 0; i < 4; i++) level_in[i] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ilc_pkg::STATUS_RESET;
         mask_ff   <= '0;
         for (int i = 0; i < 4; i++) level_ff[i] <= '0;
      end else if (ctrl.fire) begin
         status_ff <= status_in;
         mask_ff   <= mask_in;
         for (int i = 0; i < 4; i++) level_ff[i] <= level_in[i];
      end
   end

endmodule

FILE: design/interrupt_level_controller.sv
// interrupt level controller, sixteen sources behind a 32-byte register window
// req_if carries one request per transfer: a byte read, a byte write or an
// interrupt port event; rsp_if returns exactly one response per request, in
// request order (read byte, priority output, access done echo)
// a request is taken into an input register, evaluated against the register
// state in one pass and the response lands in an output register
// throughput is one request per cycle while the receiver takes responses;
// the state update of a request is seen by the very next one
// when the receiver stalls, the output register holds its response and the
// input register keeps taking one more request, after which req_if.ready drops
// the csr_ port is APB style with one register, big_endian_lanes at address 0;
// write it only while no request is in flight
// reset clears both pipeline registers and restores the status word
// (0x0000ffff), mask and level words (zero) and big_endian_lanes (one)
module interrupt_level_controller #(
   parameter int NUM_SOURCES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ilc_stream_if.sink                            req_if,
   ilc_stream_if.source                          rsp_if,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ilc_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [ilc_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [ilc_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   // input register
   logic                 req_valid_ff, req_valid_in;
   ilc_pkg::ilc_req_type req_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   ilc_pkg::ilc_rsp_type rsp_ff;
   ilc_pkg::ilc_rsp_type rsp_next;

   // lane order register
   logic                 big_endian_ff, big_endian_in;

   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   logic                 csr_write;
   ilc_pkg::ilc_ctrl_type ctrl;

   // output slot frees when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign advance   = req_valid_ff && out_free;
   assign req_if.ready = !req_valid_ff || out_free;
   assign req_take  = req_if.valid && req_if.ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) req_valid_in = 1'b1;
      else if (advance) req_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   // register state only moves when a request passes into the output slot
   assign ctrl.fire             = advance;
   assign ctrl.big_endian_lanes = big_endian_ff;

   ilc_regfile #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_regfile (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .req   (req_ff),
      .rsp   (rsp_next)
   );

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // config port, the lane order register sits at byte address 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(ilc_pkg::CSR_DATA_WIDTH-1){1'b0}}, big_endian_ff};

   always_comb begin
      big_endian_in = big_endian_ff;
      if (csr_write && csr_paddr == '0) big_endian_in = csr_pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         big_endian_ff <= 1'b1;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         big_endian_ff <= big_endian_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_if.payload;
      if (advance) rsp_ff <= rsp_next;
   end

endmodule

FILE: design/ilc_checker.sv
module ilc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ilc_pkg::ilc_rsp_type rsp_payload,
   input logic                 csr_pready
);

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // a priority number only comes with a priority output
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.ip_valid |-> rsp_payload.irq_number == ilc_pkg::IP_CLEAR)
      else $error("priority number without priority output");

   // port events never carry bus read data or access done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.ip_valid
         |-> !rsp_payload.access_done && rsp_payload.read_byte == 8'd0)
      else $error("priority output mixed with bus response");

   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("config port not ready");

endmodule

bind interrupt_level_controller ilc_checker u_ilc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload),
   .csr_pready  (csr_pready)
);
